### sv/ssil_pkg.sv
// Shared types and constants for the sorted index lookup block.
package ssil_pkg;

  localparam int KIND_W   = 2;
  localparam int POS_W    = 12;
  localparam int REC_W    = 32;
  localparam int COUNT_W  = 13;
  localparam int STRIDE_W = 17;
  localparam int SLOT_W   = 12;
  localparam int OFFSET_W = 28;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [KIND_W-1:0] KIND_LOAD        = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP_CODE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP_VEC  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_KIND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE       = 2'd2;

  localparam logic PAYLOAD_CODE = 1'b0;
  localparam logic PAYLOAD_VEC  = 1'b1;

  typedef struct packed {
    logic load_wr;
    logic start;
    logic step;
    logic set_hit;
    logic clr_res;
    logic mul;
    logic out_load;
  } ssil_cmd_t;

  typedef struct packed {
    logic kind_ok;
    logic active;
    logic match;
  } ssil_sts_t;

endpackage

### sv/ssil_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ssil_ram
  #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
  )
  (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
  );

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### sv/ssil_ctrl.sv
// Controller state machine for the sorted index lookup block.
module ssil_ctrl
  import ssil_pkg::*;
  (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_tvalid,
    output logic              in_tready,
    input  logic [KIND_W-1:0] in_kind,
    output logic              out_tvalid,
    input  logic              out_tready,
    input  ssil_sts_t         sts,
    output ssil_cmd_t         cmd
  );

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_MUL,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   in_acc;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_kind == KIND_LOAD) begin
            cmd.load_wr = 1'b1;
            cmd.clr_res = 1'b1;
            state_nxt   = S_DONE;
          end else if (sts.kind_ok) begin
            cmd.start = 1'b1;
            state_nxt = S_SEARCH;
          end else begin
            cmd.clr_res = 1'b1;
            state_nxt   = S_DONE;
          end
        end
      end
      S_SEARCH: begin
        if (!sts.active) begin
          cmd.clr_res = 1'b1;
          state_nxt   = S_DONE;
        end else if (sts.match) begin
          cmd.set_hit = 1'b1;
          state_nxt   = S_MUL;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

endmodule

### sv/ssil_dp.sv
// Datapath: config registers, index table, search bounds, offset multiply, result registers.
module ssil_dp
  import ssil_pkg::*;
  #(
    parameter int TABLE_DEPTH = 4096
  )
  (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [KIND_W-1:0]     in_kind,
    input  logic [POS_W-1:0]      in_position,
    input  logic [REC_W-1:0]      in_record_index,
    input  ssil_cmd_t             cmd,
    output ssil_sts_t             sts,
    output logic                  out_found,
    output logic [SLOT_W-1:0]     out_slot,
    output logic [OFFSET_W-1:0]   out_payload_offset
  );

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int PW = ((AW > POS_W) ? AW : POS_W) + 1;

  logic [COUNT_W-1:0]  count_r;
  logic                pkind_r;
  logic [STRIDE_W-1:0] stride_r;

  logic [REC_W-1:0]    key_r;
  logic [CW-1:0]       lo_r, hi_r;
  logic [AW-1:0]       mid_r;
  logic                res_found_r;
  logic [SLOT_W-1:0]   res_slot_r;
  logic [OFFSET_W-1:0] res_off_r;
  logic                out_found_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [OFFSET_W-1:0] out_off_r;

  logic [REC_W-1:0]    ram_q;
  logic [EW-1:0]       cnt_ext;
  logic [CW-1:0]       hi_init;
  logic [CW-1:0]       mid_ext;
  logic                key_gt;
  logic [CW-1:0]       lo_step, hi_step;
  logic [CW-1:0]       lo_nxt, hi_nxt;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW+STRIDE_W-1:0] prod;

  function automatic logic [CW-1:0] mid_of(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
    mid_of = lo + ((hi - lo) >> 1);
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      pkind_r  <= PAYLOAD_CODE;
      stride_r <= STRIDE_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ENTRY_COUNT:  count_r  <= COUNT_W'(cfg_wdata);
        CFG_PAYLOAD_KIND: pkind_r  <= cfg_wdata[0];
        CFG_STRIDE:       stride_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign sts.kind_ok = ((in_kind == KIND_LOOKUP_CODE) && (pkind_r == PAYLOAD_CODE)) ||
                       ((in_kind == KIND_LOOKUP_VEC) && (pkind_r == PAYLOAD_VEC));
  assign sts.active  = (lo_r < hi_r);
  assign sts.match   = (ram_q == key_r);

  // search range
  assign cnt_ext = EW'(count_r);
  assign hi_init = (cnt_ext > EW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cnt_ext);

  assign mid_ext = {1'b0, mid_r};
  assign key_gt  = (ram_q < key_r);
  assign lo_step = key_gt ? (mid_ext + CW'(1)) : lo_r;
  assign hi_step = key_gt ? hi_r : mid_ext;

  assign lo_nxt  = cmd.start ? '0 : lo_step;
  assign hi_nxt  = cmd.start ? hi_init : hi_step;
  assign rd_addr = AW'(mid_of(lo_nxt, hi_nxt));

  assign wr_en = cmd.load_wr && (PW'(in_position) < PW'(TABLE_DEPTH));

  ssil_ram #(
    .WIDTH (REC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_position)),
    .wr_data (in_record_index),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  assign prod = mid_r * stride_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r <= in_record_index;
    end
    if (cmd.start || cmd.step) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      mid_r <= rd_addr;
    end
    if (cmd.clr_res) begin
      res_found_r <= 1'b0;
      res_slot_r  <= '0;
      res_off_r   <= '0;
    end else if (cmd.set_hit) begin
      res_found_r <= 1'b1;
      res_slot_r  <= SLOT_W'(mid_r);
    end else if (cmd.mul) begin
      res_off_r <= OFFSET_W'(prod);
    end
    if (cmd.out_load) begin
      out_found_r <= res_found_r;
      out_slot_r  <= res_slot_r;
      out_off_r   <= res_off_r;
    end
  end

  assign out_found          = out_found_r;
  assign out_slot           = out_slot_r;
  assign out_payload_offset = out_off_r;

endmodule

### sv/sparse_sorted_index_lookup_core.sv
// Top level of the sorted index lookup block: controller, datapath, stream and config ports.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_tvalid/in_tready  | tuser kind, tdata position, record_index
//  out_    | output    | out_tvalid/out_tready| tuser found, tdata slot, payload_offset
//  cfg_    | input     | cfg_we               | cfg_addr index, cfg_wdata value
//
// Load: accept, then done. Lookup, hit or miss: accept, P probes (one table read each),
// offset multiply on a hit or empty-range check on a miss, done; P <= clog2(TABLE_DEPTH)+1.
// A lookup whose kind does not match the configured payload kind goes from accept to done.
// Synchronous active-low reset clears config and control state; no table clear.
// A finished result sits in the output register while the next transaction is accepted;
// a stalled output holds the controller in its done state until the register frees.
module sparse_sorted_index_lookup_core
  import ssil_pkg::*;
  #(
    parameter int TABLE_DEPTH = 4096
  )
  (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_tvalid,
    output logic                  in_tready,
    input  logic [47:0]           in_tdata,   // [11:0] position, [43:12] record_index, pad
    input  logic [KIND_W-1:0]     in_tuser,   // [1:0] kind
    output logic                  out_tvalid,
    input  logic                  out_tready,
    output logic [39:0]           out_tdata,  // [11:0] slot, [39:12] payload_offset
    output logic                  out_tuser   // [0] found
  );

  ssil_cmd_t           cmd;
  ssil_sts_t           sts;
  logic [SLOT_W-1:0]   slot;
  logic [OFFSET_W-1:0] offset;

  ssil_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ssil_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .in_kind            (in_tuser),
    .in_position        (in_tdata[11:0]),
    .in_record_index    (in_tdata[43:12]),
    .cmd                (cmd),
    .sts                (sts),
    .out_found          (out_tuser),
    .out_slot           (slot),
    .out_payload_offset (offset)
  );

  assign out_tdata = {offset, slot};

endmodule
